/* rtl/avr_data_transfer_unit_top_assert.svh */
// Assertion macros for the AVR data-transfer unit top level.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef AVR_DATA_TRANSFER_UNIT_TOP_ASSERT_SVH
`define AVR_DATA_TRANSFER_UNIT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADTU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ADTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/adtu_pkg.sv */
// Shared types, codes and constants of the AVR data-transfer unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package adtu_pkg;

  localparam int DATA_BYTES_DEF = 2048;
  localparam int IO_BASE_DEF    = 32;

  localparam logic [7:0] BYTE_MASK = 8'hFF;

  // Instruction codes.
  localparam logic [3:0] ACT_MOV  = 4'd0;
  localparam logic [3:0] ACT_MOVW = 4'd1;
  localparam logic [3:0] ACT_LDI  = 4'd2;
  localparam logic [3:0] ACT_LDS  = 4'd3;
  localparam logic [3:0] ACT_STS  = 4'd4;
  localparam logic [3:0] ACT_LD   = 4'd5;
  localparam logic [3:0] ACT_ST   = 4'd6;
  localparam logic [3:0] ACT_IN   = 4'd7;
  localparam logic [3:0] ACT_OUT  = 4'd8;
  localparam logic [3:0] ACT_PUSH = 4'd9;
  localparam logic [3:0] ACT_POP  = 4'd10;
  localparam logic [3:0] ACT_XCH  = 4'd11;
  localparam logic [3:0] ACT_LAS  = 4'd12;
  localparam logic [3:0] ACT_LAC  = 4'd13;
  localparam logic [3:0] ACT_LAT  = 4'd14;

  // Pointer selects and addressing modes.
  localparam logic [1:0] PSEL_X = 2'd0;
  localparam logic [1:0] PSEL_Y = 2'd1;

  localparam logic [1:0] PMODE_PLAIN   = 2'd0;
  localparam logic [1:0] PMODE_POSTINC = 2'd1;
  localparam logic [1:0] PMODE_PREDEC  = 2'd2;
  localparam logic [1:0] PMODE_DISP    = 2'd3;

  // Register pair numbers (register number divided by two).
  localparam logic [3:0] PAIR_X = 4'd13;
  localparam logic [3:0] PAIR_Y = 4'd14;
  localparam logic [3:0] PAIR_Z = 4'd15;

  typedef struct packed {
    logic [3:0]  action;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg;
    logic [7:0]  immediate;
    logic [15:0] direct_address;
    logic [1:0]  pointer_select;
    logic [1:0]  pointer_mode;
    logic [5:0]  displacement;
    logic [5:0]  io_address;
  } adtu_in_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [7:0]  byte_value;
    logic [15:0] effective_address;
    logic [15:0] pointer_after;
  } adtu_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic access;
    logic load;
    logic ptr_wb;
    logic finish;
  } adtu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_load;
    logic needs_ptr_wb;
  } adtu_stat_t;

  function automatic logic [3:0] pair_of_select(input logic [1:0] sel);
    logic [3:0] pair;
    case (sel)
      PSEL_X:  pair = PAIR_X;
      PSEL_Y:  pair = PAIR_Y;
      default: pair = PAIR_Z;
    endcase
    return pair;
  endfunction

endpackage

/* rtl/adtu_ctrl.sv */
// Sequencing state machine of the AVR data-transfer unit.
// Depends on adtu_pkg for the command and status structs.
`timescale 1ns / 1ps

module adtu_ctrl import adtu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  adtu_stat_t stat,
  output adtu_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ACCESS = 4'b0010,
    S_LOAD   = 4'b0100,
    S_PTRWB  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   finish;

  always_comb begin
    state_next = state;
    finish     = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_ACCESS;
        end
      end
      S_ACCESS: begin
        if (stat.needs_load) begin
          state_next = S_LOAD;
        end else begin
          state_next = S_IDLE;
          finish     = 1'b1;
        end
      end
      S_LOAD: begin
        if (stat.needs_ptr_wb) begin
          state_next = S_PTRWB;
        end else begin
          state_next = S_IDLE;
          finish     = 1'b1;
        end
      end
      S_PTRWB: begin
        state_next = S_IDLE;
        finish     = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  assign busy       = (state != S_IDLE);
  assign cmd.accept = (state == S_IDLE) && start;
  assign cmd.access = (state == S_ACCESS);
  assign cmd.load   = (state == S_LOAD);
  assign cmd.ptr_wb = (state == S_PTRWB);
  assign cmd.finish = finish;

endmodule

/* rtl/adtu_datapath.sv */
// Datapath of the AVR data-transfer unit: register file, data memory,
// stack pointer, program counter and result register. Depends on adtu_pkg.
`timescale 1ns / 1ps

module adtu_datapath import adtu_pkg::*; #(
  parameter int DATA_BYTES = DATA_BYTES_DEF,
  parameter int IO_BASE    = IO_BASE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  adtu_in_t   instr,
  input  adtu_cmd_t  cmd,
  output adtu_stat_t stat,
  output adtu_out_t  result
);

  localparam int AW = $clog2(DATA_BYTES);
  localparam bit IS_POW2 = ((DATA_BYTES & (DATA_BYTES - 1)) == 0);
  localparam logic [24:0] DB_W = 25'(DATA_BYTES);

  // Reduces a 16-bit address modulo DATA_BYTES. The quotient is below 256
  // because DATA_BYTES is at least 256, so eight restoring steps suffice.
  function automatic logic [AW-1:0] wrap_addr(input logic [15:0] a);
    logic [24:0] rem;
    int          k;
    rem = {9'd0, a};
    if (!IS_POW2) begin
      for (k = 7; k >= 0; k--) begin
        if (rem >= (DB_W << k)) begin
          rem = rem - (DB_W << k);
        end
      end
    end
    return rem[AW-1:0];
  endfunction

  // Register file: 16 pairs with byte enables, valid bits per byte.
  logic [15:0] rf_mem [16];
  logic [15:0] rf_vld_lo, rf_vld_hi;
  logic [15:0] rf_a_q, rf_b_q;
  logic [3:0]  rf_raddr_a, rf_raddr_b;
  logic [1:0]  rf_we;
  logic [3:0]  rf_waddr;
  logic [15:0] rf_wdata;

  // Data memory.
  logic [7:0]    dmem [DATA_BYTES];
  logic          dm_we, dm_re;
  logic [AW-1:0] dm_addr;
  logic [7:0]    dm_wdata;
  logic [7:0]    dm_rdata_q;

  adtu_in_t      instr_q;
  logic [15:0]   pc, sp;
  logic [AW-1:0] ea_q;
  logic [15:0]   np_q;
  adtu_out_t     res_q;

  logic [3:0]    ptr_pair;
  logic [1:0]    eff_mode;
  logic [15:0]   ptr, ptr_inc, ptr_dec, ptr_disp, np;
  logic [15:0]   sp_inc, sp_dec, raw_addr, pc_inc;
  logic [AW-1:0] ea_s1;
  logic [7:0]    rr_byte, rd_byte, st_byte, rmw_byte;
  logic          is_rmw, uses_mem, is_store, is_load;
  adtu_out_t     res_s1, res_late;

  always_comb begin
    case (instr.action)
      ACT_LD, ACT_ST: rf_raddr_a = pair_of_select(instr.pointer_select);
      ACT_XCH, ACT_LAS, ACT_LAC, ACT_LAT: rf_raddr_a = PAIR_Z;
      default: rf_raddr_a = instr.src_reg[4:1];
    endcase
    rf_raddr_b = instr.dest_reg[4:1];
  end

  always_comb begin
    is_rmw   = (instr_q.action == ACT_XCH) || (instr_q.action == ACT_LAS) ||
               (instr_q.action == ACT_LAC) || (instr_q.action == ACT_LAT);
    ptr_pair = is_rmw ? PAIR_Z : pair_of_select(instr_q.pointer_select);
    eff_mode = ((instr_q.pointer_select == PSEL_X) && (instr_q.pointer_mode == PMODE_DISP))
               ? PMODE_PLAIN : instr_q.pointer_mode;

    ptr      = rf_a_q;
    ptr_inc  = ptr + 16'd1;
    ptr_dec  = ptr - 16'd1;
    ptr_disp = ptr + 16'(instr_q.displacement);
    case (eff_mode)
      PMODE_POSTINC: np = ptr_inc;
      PMODE_PREDEC:  np = ptr_dec;
      default:       np = ptr;
    endcase

    sp_inc = sp + 16'd1;
    sp_dec = sp - 16'd1;
    pc_inc = pc + 16'd1;

    rr_byte = instr_q.src_reg[0] ? rf_a_q[15:8] : rf_a_q[7:0];
    rd_byte = instr_q.dest_reg[0] ? rf_b_q[15:8] : rf_b_q[7:0];

    uses_mem = 1'b1;
    is_store = 1'b0;
    is_load  = 1'b0;
    case (instr_q.action)
      ACT_LDS: begin raw_addr = instr_q.direct_address; is_load = 1'b1; end
      ACT_STS: begin raw_addr = instr_q.direct_address; is_store = 1'b1; end
      ACT_LD, ACT_ST: begin
        is_load  = (instr_q.action == ACT_LD);
        is_store = (instr_q.action == ACT_ST);
        case (eff_mode)
          PMODE_PREDEC: raw_addr = ptr_dec;
          PMODE_DISP:   raw_addr = ptr_disp;
          default:      raw_addr = ptr;
        endcase
      end
      ACT_IN: begin raw_addr = 16'(IO_BASE) + 16'(instr_q.io_address); is_load = 1'b1; end
      ACT_OUT: begin raw_addr = 16'(IO_BASE) + 16'(instr_q.io_address); is_store = 1'b1; end
      ACT_PUSH: begin raw_addr = sp; is_store = 1'b1; end
      ACT_POP: begin raw_addr = sp_inc; is_load = 1'b1; end
      ACT_XCH, ACT_LAS, ACT_LAC, ACT_LAT: begin raw_addr = ptr; is_load = 1'b1; end
      default: begin raw_addr = 16'd0; uses_mem = 1'b0; end
    endcase
    ea_s1 = wrap_addr(raw_addr);

    // OUT stores Rr; a pre-decrement store whose stored register lies in the
    // pointer pair stores the decremented byte, and other stores take Rd.
    if ((instr_q.action == ACT_OUT)) begin
      st_byte = rr_byte;
    end else if ((instr_q.action == ACT_ST) && (eff_mode == PMODE_PREDEC) &&
                 (instr_q.dest_reg[4:1] == ptr_pair)) begin
      st_byte = instr_q.dest_reg[0] ? ptr_dec[15:8] : ptr_dec[7:0];
    end else begin
      st_byte = rd_byte;
    end

    case (instr_q.action)
      ACT_XCH: rmw_byte = rd_byte;
      ACT_LAS: rmw_byte = rd_byte | dm_rdata_q;
      ACT_LAC: rmw_byte = (BYTE_MASK - rd_byte) & dm_rdata_q;
      default: rmw_byte = rd_byte ^ dm_rdata_q;
    endcase

    res_s1.next_pc           = pc_inc;
    res_s1.reg_written       = 1'b0;
    res_s1.reg_index         = instr_q.dest_reg;
    res_s1.byte_value        = 8'd0;
    res_s1.effective_address = uses_mem ? 16'(ea_s1) : 16'd0;
    res_s1.pointer_after     = 16'd0;
    case (instr_q.action)
      ACT_MOV: begin res_s1.reg_written = 1'b1; res_s1.byte_value = rr_byte; end
      ACT_MOVW: begin
        res_s1.reg_written = 1'b1;
        res_s1.reg_index   = {instr_q.dest_reg[4:1], 1'b0};
        res_s1.byte_value  = rf_a_q[7:0];
      end
      ACT_LDI: begin res_s1.reg_written = 1'b1; res_s1.byte_value = instr_q.immediate; end
      ACT_STS, ACT_PUSH: res_s1.byte_value = st_byte;
      ACT_OUT: begin res_s1.reg_index = instr_q.src_reg; res_s1.byte_value = st_byte; end
      ACT_ST: res_s1.byte_value = st_byte;
      ACT_LDS, ACT_IN, ACT_LD, ACT_POP, ACT_XCH, ACT_LAS, ACT_LAC, ACT_LAT:
        res_s1.reg_written = 1'b1;
      default: res_s1.reg_index = 5'd0;
    endcase
    case (instr_q.action)
      ACT_LD, ACT_ST: res_s1.pointer_after = np;
      ACT_XCH, ACT_LAS, ACT_LAC, ACT_LAT: res_s1.pointer_after = ptr;
      ACT_PUSH: res_s1.pointer_after = sp_dec;
      ACT_POP: res_s1.pointer_after = sp_inc;
      default: res_s1.pointer_after = 16'd0;
    endcase

    res_late            = res_q;
    res_late.byte_value = dm_rdata_q;

    stat.needs_load   = is_load;
    stat.needs_ptr_wb = (instr_q.action == ACT_LD) && (eff_mode == PMODE_POSTINC);
  end

  // Register-file and data-memory port control per step.
  always_comb begin
    rf_we    = 2'b00;
    rf_waddr = instr_q.dest_reg[4:1];
    rf_wdata = {rr_byte, rr_byte};
    dm_we    = 1'b0;
    dm_re    = 1'b0;
    dm_addr  = ea_s1;
    dm_wdata = st_byte;
    if (cmd.access) begin
      dm_we = is_store;
      dm_re = is_load;
      case (instr_q.action)
        ACT_MOV: begin
          rf_we = instr_q.dest_reg[0] ? 2'b10 : 2'b01;
        end
        ACT_MOVW: begin
          rf_we    = 2'b11;
          rf_wdata = rf_a_q;
        end
        ACT_LDI: begin
          rf_we    = instr_q.dest_reg[0] ? 2'b10 : 2'b01;
          rf_wdata = {instr_q.immediate, instr_q.immediate};
        end
        ACT_LD: begin
          if (eff_mode == PMODE_PREDEC) begin
            rf_we    = 2'b11;
            rf_waddr = ptr_pair;
            rf_wdata = np;
          end
        end
        ACT_ST: begin
          if ((eff_mode == PMODE_PREDEC) || (eff_mode == PMODE_POSTINC)) begin
            rf_we    = 2'b11;
            rf_waddr = ptr_pair;
            rf_wdata = np;
          end
        end
        default: begin
          rf_we = 2'b00;
        end
      endcase
    end else if (cmd.load) begin
      rf_we    = instr_q.dest_reg[0] ? 2'b10 : 2'b01;
      rf_wdata = {dm_rdata_q, dm_rdata_q};
      dm_addr  = ea_q;
      dm_wdata = rmw_byte;
      dm_we    = is_rmw;
    end else if (cmd.ptr_wb) begin
      rf_we    = 2'b11;
      rf_waddr = ptr_pair;
      rf_wdata = np_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we[0]) begin
      rf_mem[rf_waddr][7:0] <= rf_wdata[7:0];
    end
    if (rf_we[1]) begin
      rf_mem[rf_waddr][15:8] <= rf_wdata[15:8];
    end
    if (cmd.accept) begin
      rf_a_q <= {rf_vld_hi[rf_raddr_a] ? rf_mem[rf_raddr_a][15:8] : 8'h00,
                 rf_vld_lo[rf_raddr_a] ? rf_mem[rf_raddr_a][7:0]  : 8'h00};
      rf_b_q <= {rf_vld_hi[rf_raddr_b] ? rf_mem[rf_raddr_b][15:8] : 8'h00,
                 rf_vld_lo[rf_raddr_b] ? rf_mem[rf_raddr_b][7:0]  : 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dmem[dm_addr] <= dm_wdata;
    end
    if (dm_re) begin
      dm_rdata_q <= dmem[dm_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld_lo <= '0;
      rf_vld_hi <= '0;
      pc        <= 16'd0;
      sp        <= 16'(DATA_BYTES - 1);
    end else begin
      if (rf_we[0]) begin
        rf_vld_lo[rf_waddr] <= 1'b1;
      end
      if (rf_we[1]) begin
        rf_vld_hi[rf_waddr] <= 1'b1;
      end
      if (cmd.finish) begin
        pc <= pc_inc;
      end
      if (cmd.access && (instr_q.action == ACT_PUSH)) begin
        sp <= sp_dec;
      end else if (cmd.access && (instr_q.action == ACT_POP)) begin
        sp <= sp_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      instr_q <= instr;
    end
    if (cmd.access) begin
      ea_q  <= ea_s1;
      np_q  <= np;
      res_q <= res_s1;
    end
    if (cmd.finish) begin
      result <= cmd.access ? res_s1 : res_late;
    end
  end

endmodule

/* rtl/avr_data_transfer_unit_top.sv */
// Top level of the AVR data-transfer unit: controller plus datapath.
// Depends on adtu_pkg, adtu_ctrl, adtu_datapath and the assertion header.
`timescale 1ns / 1ps
`include "avr_data_transfer_unit_top_assert.svh"

// The unit executes one AVR data-transfer instruction per input beat. A beat
// is taken at a rising edge where start is high and busy is low; its result
// appears on result for exactly one cycle, marked by done, and the receiver
// cannot stall it, so it must take the beat in that cycle. One instruction is
// in flight at a time. Register-only instructions and all stores need only an
// access step, loads and the atomic read-modify-write forms at Z add a load
// step, and a post-increment load adds a pointer write-back step after it;
// a new beat is taken once the unit is idle again. The steps are set by the
// registered register-file read done at accept, the registered data-memory
// read port, and the single register-file write port, which forces the
// post-increment pointer update into its own step after the loaded byte. The
// register file clears at reset through per-byte valid bits, so no clearing
// pass is needed and the unit is ready right after reset. Data memory is not
// cleared; a location must be written before it is read.

module avr_data_transfer_unit_top import adtu_pkg::*; #(
  parameter int DATA_BYTES = DATA_BYTES_DEF,
  parameter int IO_BASE    = IO_BASE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  adtu_in_t  instr,
  output logic      done,
  output adtu_out_t result
);

  // Command and status structs are the only link between the two halves.
  adtu_cmd_t  cmd;
  adtu_stat_t stat;

  // The controller steps through access, load and pointer write-back as the
  // instruction needs, and raises done in the cycle after its final step.
  adtu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // The datapath holds all architectural state and the result register.
  adtu_datapath #(
    .DATA_BYTES (DATA_BYTES),
    .IO_BASE    (IO_BASE)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

  // A result beat is only shown once the unit has gone back to idle.
  `ADTU_ASSERT_SAME(a_done_idle, done, !busy, "done raised while busy")
  // An accepted beat makes the unit busy in the following cycle.
  `ADTU_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accept did not start work")
  // At most one step of the sequence is active in any cycle.
  `ADTU_ASSERT_SAME(a_one_step, 1'b1,
    $onehot0({cmd.accept, cmd.access, cmd.load, cmd.ptr_wb}), "overlapping steps")

endmodule

/* verif/avr_data_transfer_unit_top_tb.sv */
// Self-checking testbench for the AVR data-transfer unit top level.
// Depends on adtu_pkg and avr_data_transfer_unit_top; needs no files or arguments.
`timescale 1ns / 1ps

module avr_data_transfer_unit_top_tb;
  import adtu_pkg::*;

  localparam int DATA_BYTES       = DATA_BYTES_DEF;
  localparam int IO_BASE          = IO_BASE_DEF;
  localparam int CLK_PERIOD       = 10;
  localparam int RESET_CYCLES     = 7;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_CYCLES     = 8;
  localparam int RANDOM_PER_PHASE = 160;

  // Action code with no instruction behind it; it only advances the PC.
  localparam logic [3:0] ACT_UNUSED = 4'd15;

  // Pointer select codes the package leaves out. Code three aliases Z.
  localparam logic [1:0] PSEL_Z       = 2'd2;
  localparam logic [1:0] PSEL_ALIAS_Z = 2'd3;

  // Register numbers of the pointer pairs, low byte in the even register.
  localparam logic [4:0] REG_XL = 5'd26;
  localparam logic [4:0] REG_YL = 5'd28;
  localparam logic [4:0] REG_ZL = 5'd30;
  localparam logic [4:0] REG_ZH = 5'd31;

  typedef struct {
    adtu_in_t  op;
    bit        pinned;
    adtu_out_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      start;
  logic      busy;
  adtu_in_t  instr;
  logic      done;
  adtu_out_t result;

  // Architectural state as this testbench tracks it, updated at every
  // accepted beat. dmem_written marks the bytes that are legal to read.
  logic [7:0]  regs [32];
  logic [7:0]  dmem [DATA_BYTES];
  bit          dmem_written [DATA_BYTES];
  logic [15:0] sp_model;
  logic [15:0] pc_model;

  adtu_out_t pending_results [$];
  stim_row_t directed_rows [$];

  // Hand-off from the driver to the scoreboard: the result that the beat now
  // on the bus must produce when it was typed into the directed rows.
  bit        beat_pinned;
  adtu_out_t beat_want;
  int        beats_taken = 0;
  int        mismatches  = 0;
  int        cycles      = 0;

  avr_data_transfer_unit_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .instr  (instr),
    .done   (done),
    .result (result)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic logic [4:0] pair_low(input logic [1:0] sel);
    case (sel)
      PSEL_X:  return REG_XL;
      PSEL_Y:  return REG_YL;
      default: return REG_ZL;
    endcase
  endfunction

  function automatic logic [15:0] pair_value(input logic [4:0] lo);
    return {regs[lo | 5'd1], regs[lo]};
  endfunction

  function automatic void write_pair(input logic [4:0] lo, input logic [15:0] v);
    regs[lo]        = v[7:0];
    regs[lo | 5'd1] = v[15:8];
  endfunction

  function automatic void store_byte(input logic [15:0] ea, input logic [7:0] v);
    dmem[ea]         = v;
    dmem_written[ea] = 1'b1;
  endfunction

  // Data address an instruction touches, computed from the state before it
  // runs and already reduced to the data space. reads says whether the
  // instruction loads from that address.
  function automatic logic [15:0] data_address(input adtu_in_t i, output bit reads);
    logic [15:0] p;
    logic [15:0] addr16;
    logic [1:0]  mode;
    reads  = 1'b0;
    addr16 = '0;
    p      = pair_value(pair_low(i.pointer_select));
    mode   = i.pointer_mode;
    // X has no displacement form; the offset is dropped.
    if (i.pointer_select == PSEL_X && mode == PMODE_DISP) mode = PMODE_PLAIN;
    case (i.action)
      ACT_LDS, ACT_STS: begin
        addr16 = i.direct_address;
        reads  = (i.action == ACT_LDS);
      end
      ACT_LD, ACT_ST: begin
        reads = (i.action == ACT_LD);
        case (mode)
          PMODE_PREDEC: addr16 = p - 16'd1;
          PMODE_DISP:   addr16 = p + {10'd0, i.displacement};
          default:      addr16 = p;
        endcase
      end
      ACT_IN, ACT_OUT: begin
        addr16 = 16'(IO_BASE) + {10'd0, i.io_address};
        reads  = (i.action == ACT_IN);
      end
      ACT_PUSH: addr16 = sp_model;
      ACT_POP: begin
        addr16 = sp_model + 16'd1;
        reads  = 1'b1;
      end
      ACT_XCH, ACT_LAS, ACT_LAC, ACT_LAT: begin
        addr16 = pair_value(REG_ZL);
        reads  = 1'b1;
      end
      default: addr16 = '0;
    endcase
    return 16'(addr16 % DATA_BYTES);
  endfunction

  // Runs one instruction against the tracked state and returns its result.
  function automatic adtu_out_t execute_transfer(input adtu_in_t i);
    adtu_out_t   o;
    bit          reads;
    logic [15:0] ea;
    logic [4:0]  d;
    logic [4:0]  r;
    logic [4:0]  lo;
    logic [15:0] p;
    logic [15:0] np;
    logic [1:0]  mode;
    logic [7:0]  old;
    logic [7:0]  rd;
    logic [7:0]  nv;
    o                   = '0;
    o.reg_index         = i.dest_reg;
    ea                  = data_address(i, reads);
    o.effective_address = ea;
    d                   = i.dest_reg;
    r                   = i.src_reg;
    case (i.action)
      ACT_MOV: begin
        o.byte_value  = regs[r];
        regs[d]       = regs[r];
        o.reg_written = 1'b1;
      end
      ACT_MOVW: begin
        d[0]           = 1'b0;
        r[0]           = 1'b0;
        regs[d]        = regs[r];
        regs[d | 5'd1] = regs[r | 5'd1];
        o.byte_value   = regs[d];
        o.reg_index    = d;
        o.reg_written  = 1'b1;
      end
      ACT_LDI: begin
        o.byte_value  = i.immediate;
        regs[d]       = i.immediate;
        o.reg_written = 1'b1;
      end
      ACT_LDS, ACT_IN: begin
        o.byte_value  = dmem[ea];
        regs[d]       = dmem[ea];
        o.reg_written = 1'b1;
      end
      ACT_STS: begin
        o.byte_value = regs[d];
        store_byte(ea, regs[d]);
      end
      ACT_LD, ACT_ST: begin
        lo   = pair_low(i.pointer_select);
        p    = pair_value(lo);
        np   = p;
        mode = i.pointer_mode;
        if (i.pointer_select == PSEL_X && mode == PMODE_DISP) mode = PMODE_PLAIN;
        // Pre-decrement lands in the pair before the data move, so an Rd
        // inside the pair sees the decremented byte; post-increment lands
        // after it and wins over a load into the pair.
        if (mode == PMODE_POSTINC) begin
          np = p + 16'd1;
        end else if (mode == PMODE_PREDEC) begin
          np = p - 16'd1;
          write_pair(lo, np);
        end
        if (i.action == ACT_LD) begin
          o.byte_value  = dmem[ea];
          regs[d]       = dmem[ea];
          o.reg_written = 1'b1;
        end else begin
          o.byte_value = regs[d];
          store_byte(ea, regs[d]);
        end
        if (mode == PMODE_POSTINC) write_pair(lo, np);
        o.pointer_after = np;
      end
      ACT_OUT: begin
        o.reg_index  = r;
        o.byte_value = regs[r];
        store_byte(ea, regs[r]);
      end
      ACT_PUSH: begin
        o.byte_value = regs[d];
        store_byte(ea, regs[d]);
        sp_model        = sp_model - 16'd1;
        o.pointer_after = sp_model;
      end
      ACT_POP: begin
        sp_model        = sp_model + 16'd1;
        o.byte_value    = dmem[ea];
        regs[d]         = dmem[ea];
        o.reg_written   = 1'b1;
        o.pointer_after = sp_model;
      end
      ACT_XCH, ACT_LAS, ACT_LAC, ACT_LAT: begin
        old = dmem[ea];
        rd  = regs[d];
        case (i.action)
          ACT_XCH: nv = rd;
          ACT_LAS: nv = rd | old;
          ACT_LAC: nv = ~rd & old;
          default: nv = rd ^ old;
        endcase
        o.pointer_after = pair_value(REG_ZL);
        store_byte(ea, nv);
        regs[d]       = old;
        o.byte_value  = old;
        o.reg_written = 1'b1;
      end
      default: o.reg_index = '0;
    endcase
    pc_model  = pc_model + 16'd1;
    o.next_pc = pc_model;
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic adtu_in_t mk_instr(input logic [3:0] act, input logic [4:0] d,
                                        input logic [4:0] r, input logic [7:0] k,
                                        input logic [15:0] addr, input logic [1:0] psel,
                                        input logic [1:0] pmode, input logic [5:0] q,
                                        input logic [5:0] a);
    adtu_in_t i;
    i.action         = act;
    i.dest_reg       = d;
    i.src_reg        = r;
    i.immediate      = k;
    i.direct_address = addr;
    i.pointer_select = psel;
    i.pointer_mode   = pmode;
    i.displacement   = q;
    i.io_address     = a;
    return i;
  endfunction

  function automatic adtu_out_t mk_result(input logic [15:0] pc, input logic wr,
                                          input logic [4:0] idx, input logic [7:0] v,
                                          input logic [15:0] ea, input logic [15:0] pa);
    adtu_out_t o;
    o.next_pc           = pc;
    o.reg_written       = wr;
    o.reg_index         = idx;
    o.byte_value        = v;
    o.effective_address = ea;
    o.pointer_after     = pa;
    return o;
  endfunction

  task automatic add_row(input adtu_in_t op, input bit pinned, input adtu_out_t want);
    stim_row_t row;
    row.op     = op;
    row.pinned = pinned;
    row.want   = want;
    directed_rows.push_back(row);
  endtask

  // A 16-bit value that lands in one of a few small windows of the data
  // space (bottom, just above it, and the top where addresses wrap). The
  // upper bits are random since the data space ignores them.
  function automatic logic [15:0] hot_pointer();
    logic [2:0] page;
    case ($urandom_range(0, 2))
      0:       page = 3'd0;
      1:       page = 3'd1;
      default: page = 3'd7;
    endcase
    return {5'($urandom), page, ($urandom_range(0, 1) ? 4'hF : 4'h0), 4'($urandom)};
  endfunction

  // Draws a random instruction. Pointer registers are often reloaded with
  // values in the hot windows so that loads, stores and the stack keep
  // meeting each other. Any draw that would read a byte nobody wrote yet is
  // thrown away; ldi never reads, so it is the way out of a long bad streak.
  function automatic adtu_in_t pick_instr();
    adtu_in_t    i;
    logic [15:0] hot;
    logic [15:0] ea;
    bit          reads;
    int          tries;
    for (tries = 0; tries < 40; tries++) begin
      i.action         = 4'($urandom_range(0, 15));
      i.dest_reg       = 5'($urandom);
      i.src_reg        = 5'($urandom);
      i.immediate      = 8'($urandom);
      i.direct_address = $urandom_range(0, 1) ? hot_pointer() : 16'($urandom);
      i.pointer_select = 2'($urandom);
      i.pointer_mode   = 2'($urandom);
      i.displacement   = 6'($urandom);
      i.io_address     = 6'($urandom);
      if ($urandom_range(0, 99) < 20) begin
        hot         = hot_pointer();
        i.action    = ACT_LDI;
        i.dest_reg  = 5'($urandom_range(REG_XL, REG_ZH));
        i.immediate = i.dest_reg[0] ? hot[15:8] : hot[7:0];
      end
      ea = data_address(i, reads);
      if (!reads || dmem_written[ea]) return i;
    end
    i.action = ACT_LDI;
    return i;
  endfunction

  // Puts one beat on the bus at a falling edge and holds it until the unit
  // takes it. Before that the sender may sit idle for a random stretch.
  task automatic send_beat(input adtu_in_t op, input bit pinned, input adtu_out_t want,
                           input int idle_pct);
    int seen;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    seen        = beats_taken;
    beat_pinned = pinned;
    beat_want   = want;
    instr <= op;
    start <= 1'b1;
    do @(negedge clk); while (beats_taken == seen);
  endtask

  task automatic check_beat(input adtu_out_t want, input adtu_out_t got);
    bit bad;
    bad = 1'b0;
    if (got.next_pc !== want.next_pc) begin
      $error("next_pc: expected %0h, got %0h", want.next_pc, got.next_pc);
      bad = 1'b1;
    end
    if (got.reg_written !== want.reg_written) begin
      $error("reg_written: expected %0b, got %0b", want.reg_written, got.reg_written);
      bad = 1'b1;
    end
    if (got.reg_index !== want.reg_index) begin
      $error("reg_index: expected %0d, got %0d", want.reg_index, got.reg_index);
      bad = 1'b1;
    end
    if (got.byte_value !== want.byte_value) begin
      $error("byte_value: expected %0h, got %0h", want.byte_value, got.byte_value);
      bad = 1'b1;
    end
    if (got.effective_address !== want.effective_address) begin
      $error("effective_address: expected %0h, got %0h",
             want.effective_address, got.effective_address);
      bad = 1'b1;
    end
    if (got.pointer_after !== want.pointer_after) begin
      $error("pointer_after: expected %0h, got %0h", want.pointer_after, got.pointer_after);
      bad = 1'b1;
    end
    if (bad) mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Scoreboard. Inputs move on falling edges, so at a rising edge every
  // signal read here is stable. A result beat is handled before a new
  // instruction beat at the same edge, because only one instruction is in
  // flight and the result always belongs to the older one.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    adtu_out_t predicted;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no instruction outstanding");
          mismatches++;
        end else begin
          check_beat(pending_results.pop_front(), result);
        end
      end
      if (start && !busy) begin
        // Pinned rows still run through the predictor so that the tracked
        // state stays in step with the unit.
        predicted = execute_transfer(instr);
        pending_results.push_back(beat_pinned ? beat_want : predicted);
        beats_taken++;
      end
    end
  end

  // Watchdog on a hung handshake or a lost result.
  always @(posedge clk) begin : watchdog
    if (cycles < CYCLE_LIMIT) begin
      cycles++;
    end else begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int idle_pct [3];
    int phase;
    int n;
    rst         = 1'b1;
    start       = 1'b0;
    instr       = '0;
    beat_pinned = 1'b0;
    beat_want   = '0;
    idle_pct    = '{34, 83, 0};
    foreach (regs[k]) regs[k] = '0;
    foreach (dmem_written[k]) dmem_written[k] = 1'b0;
    sp_model = 16'(DATA_BYTES - 1);
    pc_model = '0;

    // Directed rows. The first ten follow reset directly, so their results
    // are written out in full: the register file is zero, the stack pointer
    // sits at the top of the data space and the PC counts from one.
    add_row(mk_instr(ACT_MOV, 5'd0, 5'd31, 8'h00, 16'h0000, PSEL_X, PMODE_PLAIN, 6'd0, 6'd0),
            1'b1, mk_result(16'd1, 1'b1, 5'd0, 8'h00, 16'h0000, 16'h0000));
    add_row(mk_instr(ACT_LDI, 5'd31, 5'd0, 8'hFF, 16'h0000, PSEL_X, PMODE_PLAIN, 6'd0, 6'd0),
            1'b1, mk_result(16'd2, 1'b1, 5'd31, 8'hFF, 16'h0000, 16'h0000));
    // ldi into the lower half of the register file is accepted as well.
    add_row(mk_instr(ACT_LDI, 5'd15, 5'd0, 8'h5A, 16'h0000, PSEL_X, PMODE_PLAIN, 6'd0, 6'd0),
            1'b1, mk_result(16'd3, 1'b1, 5'd15, 8'h5A, 16'h0000, 16'h0000));
    // The spare action code only moves the PC, whatever the other fields say.
    add_row(mk_instr(ACT_UNUSED, 5'd7, 5'd9, 8'hC3, 16'hBEEF, PSEL_Y, PMODE_DISP, 6'd21,
                     6'd42),
            1'b1, mk_result(16'd4, 1'b0, 5'd0, 8'h00, 16'h0000, 16'h0000));
    add_row(mk_instr(ACT_PUSH, 5'd31, 5'd0, 8'h00, 16'h0000, PSEL_X, PMODE_PLAIN, 6'd0, 6'd0),
            1'b1, mk_result(16'd5, 1'b0, 5'd31, 8'hFF, 16'h07FF, 16'h07FE));
    add_row(mk_instr(ACT_POP, 5'd1, 5'd0, 8'h00, 16'h0000, PSEL_X, PMODE_PLAIN, 6'd0, 6'd0),
            1'b1, mk_result(16'd6, 1'b1, 5'd1, 8'hFF, 16'h07FF, 16'h07FF));
    // Largest direct address wraps onto the last data byte.
    add_row(mk_instr(ACT_STS, 5'd15, 5'd0, 8'h00, 16'hFFFF, PSEL_X, PMODE_PLAIN, 6'd0, 6'd0),
            1'b1, mk_result(16'd7, 1'b0, 5'd15, 8'h5A, 16'h07FF, 16'h0000));
    add_row(mk_instr(ACT_LDS, 5'd2, 5'd0, 8'h00, 16'h07FF, PSEL_X, PMODE_PLAIN, 6'd0, 6'd0),
            1'b1, mk_result(16'd8, 1'b1, 5'd2, 8'h5A, 16'h07FF, 16'h0000));
    add_row(mk_instr(ACT_OUT, 5'd0, 5'd31, 8'h00, 16'h0000, PSEL_X, PMODE_PLAIN, 6'd0, 6'd63),
            1'b1, mk_result(16'd9, 1'b0, 5'd31, 8'hFF, 16'(IO_BASE + 63), 16'h0000));
    add_row(mk_instr(ACT_IN, 5'd3, 5'd0, 8'h00, 16'h0000, PSEL_X, PMODE_PLAIN, 6'd0, 6'd63),
            1'b1, mk_result(16'd10, 1'b1, 5'd3, 8'hFF, 16'(IO_BASE + 63), 16'h0000));
    // From here on the predictor supplies the expected results.
    // movw with odd register numbers, which drop their low bit.
    add_row(mk_instr(ACT_MOVW, 5'd5, 5'd31, 8'h00, 16'h0000, PSEL_X, PMODE_PLAIN, 6'd0, 6'd0),
            1'b0, '0);
    // Z = 0x07FE, just under the top of the data space.
    add_row(mk_instr(ACT_LDI, REG_ZL, 5'd0, 8'hFE, 16'h0000, PSEL_X, PMODE_PLAIN, 6'd0, 6'd0),
            1'b0, '0);
    add_row(mk_instr(ACT_LDI, REG_ZH, 5'd0, 8'h07, 16'h0000, PSEL_X, PMODE_PLAIN, 6'd0, 6'd0),
            1'b0, '0);
    add_row(mk_instr(ACT_ST, 5'd15, 5'd0, 8'h00, 16'h0000, PSEL_Z, PMODE_POSTINC, 6'd0, 6'd0),
            1'b0, '0);
    add_row(mk_instr(ACT_LD, REG_XL, 5'd0, 8'h00, 16'h0000, PSEL_Z, PMODE_PREDEC, 6'd0, 6'd0),
            1'b0, '0);
    // Largest displacement carries Z past the top, so the address wraps.
    add_row(mk_instr(ACT_ST, REG_ZH, 5'd0, 8'h00, 16'h0000, PSEL_Z, PMODE_DISP, 6'd63, 6'd0),
            1'b0, '0);
    add_row(mk_instr(ACT_LD, 5'd6, 5'd0, 8'h00, 16'h0000, PSEL_Z, PMODE_DISP, 6'd63, 6'd0),
            1'b0, '0);
    // X in displacement mode behaves as plain X.
    add_row(mk_instr(ACT_ST, 5'd2, 5'd0, 8'h00, 16'h0000, PSEL_X, PMODE_DISP, 6'd40, 6'd0),
            1'b0, '0);
    // Pointer select three addresses through Z.
    add_row(mk_instr(ACT_LD, 5'd8, 5'd0, 8'h00, 16'h0000, PSEL_ALIAS_Z, PMODE_PLAIN, 6'd0,
                     6'd0),
            1'b0, '0);
    add_row(mk_instr(ACT_XCH, 5'd15, 5'd0, 8'h00, 16'h0000, PSEL_X, PMODE_PLAIN, 6'd0, 6'd0),
            1'b0, '0);
    add_row(mk_instr(ACT_LAS, 5'd7, 5'd0, 8'h00, 16'h0000, PSEL_X, PMODE_PLAIN, 6'd0, 6'd0),
            1'b0, '0);
    add_row(mk_instr(ACT_LAC, 5'd2, 5'd0, 8'h00, 16'h0000, PSEL_X, PMODE_PLAIN, 6'd0, 6'd0),
            1'b0, '0);
    add_row(mk_instr(ACT_LAT, 5'd3, 5'd0, 8'h00, 16'h0000, PSEL_X, PMODE_PLAIN, 6'd0, 6'd0),
            1'b0, '0);
    // Load into the low byte of X through X+: the increment overwrites it.
    add_row(mk_instr(ACT_LD, REG_XL, 5'd0, 8'h00, 16'h0000, PSEL_X, PMODE_POSTINC, 6'd0, 6'd0),
            1'b0, '0);
    // Store of the low byte of Y through -Y: Y wraps from zero to 0xFFFF and
    // the stored byte is the decremented one.
    add_row(mk_instr(ACT_ST, REG_YL, 5'd0, 8'h00, 16'h0000, PSEL_Y, PMODE_PREDEC, 6'd0, 6'd0),
            1'b0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      send_beat(directed_rows[k].op, directed_rows[k].pinned, directed_rows[k].want,
                idle_pct[0]);
    end

    // Random part in three phases of sender behavior: light idling, heavy
    // idling, then back-to-back beats. The result side has no stall to vary.
    for (phase = 0; phase < 3; phase++) begin
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_beat(pick_instr(), 1'b0, '0, idle_pct[phase]);
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    // A final drain wait catches any stray result beat.
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
